// ===== hw/rtl/des_pkcs_pkg.sv =====
// Package with DES tables, permutation functions and shared constants.
package des_pkcs_pkg;

    localparam int unsigned BLOCK_BYTES = 8;
    localparam int unsigned PAD_LIMIT = 9;
    localparam int unsigned ROUNDS = 16;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VECTOR = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 4'd3;

    localparam logic [63:0] PAD_FULL_BLOCK = 64'h0808080808080808;

    localparam logic [6:0] TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam logic [6:0] TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam logic [5:0] TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam logic [5:0] TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam logic [6:0] TAB_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
        19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam logic [5:0] TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};
    localparam logic [4:0] TAB_ROT_SUM [16] = '{
        1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};
    localparam logic [3:0] TAB_S [512] = '{
        14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13,
        15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9,
        10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12,
        7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14,
        2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3,
        12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13,
        4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12,
        13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11};

    function automatic logic [63:0] perm_ip(logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) begin
            r[63-i] = v[64-int'(TAB_IP[i])];
        end
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) begin
            r[63-i] = v[64-int'(TAB_FP[i])];
        end
        return r;
    endfunction

    function automatic logic [47:0] perm_e(logic [31:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) begin
            r[47-i] = v[32-int'(TAB_E[i])];
        end
        return r;
    endfunction

    function automatic logic [31:0] perm_p(logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[31-i] = v[32-int'(TAB_P[i])];
        end
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) begin
            r[55-i] = v[64-int'(TAB_PC1[i])];
        end
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) begin
            r[47-i] = v[56-int'(TAB_PC2[i])];
        end
        return r;
    endfunction

    function automatic logic [27:0] rotl28(logic [27:0] v, int unsigned n);
        logic [55:0] t;
        t = {v, v} << n;
        return t[55:28];
    endfunction

endpackage

// ===== hw/rtl/des_pkcs_ifs.sv =====
// Stream and configuration channel interfaces of the DES cipher.
interface des_pkcs_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] in_block;
    logic [3:0]  in_valid_bytes;
    logic        in_last;
    modport source (output valid, in_block, in_valid_bytes, in_last, input ready);
    modport sink (input valid, in_block, in_valid_bytes, in_last, output ready);
endinterface

interface des_pkcs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_block;
    logic [3:0]  out_valid_bytes;
    logic        out_last;
    logic        bad_padding;
    modport source (output valid, out_block, out_valid_bytes, out_last, bad_padding,
                    input ready);
    modport sink (input valid, out_block, out_valid_bytes, out_last, bad_padding,
                  output ready);
endinterface

interface des_pkcs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [des_pkcs_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                         data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/des_pkcs_round.sv =====
// One DES Feistel round.
module des_pkcs_round (
    input  logic [31:0] i_left,
    input  logic [31:0] i_right,
    input  logic [47:0] i_subkey,
    output logic [31:0] o_left,
    output logic [31:0] o_right
);

    logic [47:0] expanded;
    logic [31:0] sbox_out;

    always_comb begin
        logic [5:0] six;
        expanded = des_pkcs_pkg::perm_e(i_right) ^ i_subkey;
        for (int b = 0; b < 8; b++) begin
            six = expanded[47-6*b -: 6];
            sbox_out[31-4*b -: 4] =
                des_pkcs_pkg::TAB_S[{3'(b), six[5], six[0], six[4:1]}];
        end
    end

    assign o_left = i_right;
    assign o_right = i_left ^ des_pkcs_pkg::perm_p(sbox_out);

endmodule

// ===== hw/rtl/des_pkcs_core.sv =====
// DES block function: key schedule, permutations and sixteen rounds.
module des_pkcs_core (
    input  logic [63:0] i_block,
    input  logic [63:0] i_key,
    input  logic        i_decrypt,
    output logic [63:0] o_block
);

    logic [55:0] key_cd;
    logic [47:0] subkey [des_pkcs_pkg::ROUNDS];
    logic [63:0] ip_block;
    logic [31:0] left [des_pkcs_pkg::ROUNDS+1];
    logic [31:0] right [des_pkcs_pkg::ROUNDS+1];

    assign key_cd = des_pkcs_pkg::perm_pc1(i_key);
    assign ip_block = des_pkcs_pkg::perm_ip(i_block);
    assign left[0] = ip_block[63:32];
    assign right[0] = ip_block[31:0];

    for (genvar g = 0; g < des_pkcs_pkg::ROUNDS; g++) begin : g_round
        assign subkey[g] = des_pkcs_pkg::perm_pc2({
            des_pkcs_pkg::rotl28(key_cd[55:28], des_pkcs_pkg::TAB_ROT_SUM[g]),
            des_pkcs_pkg::rotl28(key_cd[27:0], des_pkcs_pkg::TAB_ROT_SUM[g])});

        des_pkcs_round u_round (
            .i_left  (left[g]),
            .i_right (right[g]),
            .i_subkey(i_decrypt ? subkey[des_pkcs_pkg::ROUNDS-1-g] : subkey[g]),
            .o_left  (left[g+1]),
            .o_right (right[g+1])
        );
    end

    assign o_block = des_pkcs_pkg::perm_fp({right[des_pkcs_pkg::ROUNDS],
                                            left[des_pkcs_pkg::ROUNDS]});

endmodule

// ===== hw/rtl/des_block_mode_pkcs7_cipher.sv =====
// Top level: DES ECB/CBC cipher with PKCS7 padding and pad removal.
// Throughput: one word per cycle while the output is not stalled; a full last
// encrypt word also sends an added pad block through the cipher, which chains on its own result.
// The sixteen-round DES function sits between the input and result registers.
// Reset (synchronous, active low) empties both registers, restores register defaults.
module des_block_mode_pkcs7_cipher (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    des_pkcs_cfg_if.sink           i_cfg,
    des_pkcs_in_if.sink            i_in_ch,
    des_pkcs_out_if.source         o_out_ch
);

    logic [63:0] r_key;
    logic [63:0] r_iv;
    logic        r_cbc;
    logic        r_dec;
    logic [63:0] r_chain;
    logic        r_msg_start;

    logic        r_in_valid;
    logic [63:0] r_in_block;
    logic [3:0]  r_in_bytes;
    logic        r_in_last;
    logic        r_pad_phase;

    logic        r_out_valid;
    logic [63:0] r_out_block;
    logic [3:0]  r_out_bytes;
    logic        r_out_last;
    logic        r_out_bad;

    logic        fire;
    logic        need_second;
    logic        in_accept;
    logic [63:0] chain_cur;
    logic [63:0] enc_plain;
    logic [63:0] core_in;
    logic [63:0] core_out;
    logic [63:0] dec_plain;
    logic [63:0] n_chain;
    logic [63:0] n_out_block;
    logic [3:0]  n_out_bytes;
    logic        n_out_last;
    logic        n_out_bad;

    assign i_cfg.ready = 1'b1;

    assign fire = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign need_second = !r_dec && r_in_last && !r_pad_phase
                         && (r_in_bytes >= 4'(des_pkcs_pkg::BLOCK_BYTES));
    assign i_in_ch.ready = !r_in_valid || (fire && !need_second);
    assign in_accept = i_in_ch.valid && i_in_ch.ready;

    assign chain_cur = (r_msg_start && !r_pad_phase) ? r_iv : r_chain;

    always_comb begin
        enc_plain = r_in_block;
        if (r_pad_phase) begin
            enc_plain = des_pkcs_pkg::PAD_FULL_BLOCK;
        end else if (r_in_last && r_in_bytes < 4'(des_pkcs_pkg::BLOCK_BYTES)) begin
            for (int j = 0; j < 8; j++) begin
                if (4'(j) < 4'(8) - r_in_bytes) begin
                    enc_plain[8*j +: 8] = 8'(4'(8) - r_in_bytes);
                end
            end
        end
    end

    assign core_in = r_dec ? r_in_block : (enc_plain ^ (r_cbc ? chain_cur : 64'd0));

    des_pkcs_core u_core (
        .i_block  (core_in),
        .i_key    (r_key),
        .i_decrypt(r_dec),
        .o_block  (core_out)
    );

    assign dec_plain = core_out ^ (r_cbc ? chain_cur : 64'd0);

    always_comb begin
        logic [7:0] pad;
        logic       ok;
        pad = dec_plain[7:0];
        ok = (pad != 8'd0) && (pad < 8'(des_pkcs_pkg::PAD_LIMIT));
        n_out_block = core_out;
        n_out_bytes = 4'(des_pkcs_pkg::BLOCK_BYTES);
        n_out_last = 1'b0;
        n_out_bad = 1'b0;
        n_chain = r_cbc ? (r_dec ? r_in_block : core_out) : chain_cur;
        if (!r_dec) begin
            n_out_last = r_in_last && !need_second;
        end else begin
            n_out_block = dec_plain;
            if (r_in_last) begin
                n_out_last = 1'b1;
                for (int j = 0; j < 8; j++) begin
                    if (8'(j) < pad) begin
                        n_out_block[8*j +: 8] = 8'd0;
                        if (dec_plain[8*j +: 8] != pad) begin
                            ok = 1'b0;
                        end
                    end
                end
                if (ok) begin
                    n_out_bytes = 4'(des_pkcs_pkg::BLOCK_BYTES) - pad[3:0];
                end else begin
                    n_out_block = 64'd0;
                    n_out_bytes = 4'd0;
                    n_out_bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= 64'd0;
            r_iv <= 64'd0;
            r_cbc <= 1'b1;
            r_dec <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                des_pkcs_pkg::REG_CIPHER_KEY: r_key <= i_cfg.data;
                des_pkcs_pkg::REG_INIT_VECTOR: r_iv <= i_cfg.data;
                des_pkcs_pkg::REG_CHAIN_MODE: r_cbc <= i_cfg.data[0];
                des_pkcs_pkg::REG_DECRYPT_MODE: r_dec <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= 64'd0;
            r_msg_start <= 1'b1;
            r_in_valid <= 1'b0;
            r_pad_phase <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_chain <= n_chain;
                r_msg_start <= r_in_last;
                r_pad_phase <= need_second;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire && !need_second) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_block <= i_in_ch.in_block;
            r_in_bytes <= i_in_ch.in_valid_bytes;
            r_in_last <= i_in_ch.in_last;
        end
        if (fire) begin
            r_out_block <= n_out_block;
            r_out_bytes <= n_out_bytes;
            r_out_last <= n_out_last;
            r_out_bad <= n_out_bad;
        end
    end

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.out_block = r_out_block;
    assign o_out_ch.out_valid_bytes = r_out_bytes;
    assign o_out_ch.out_last = r_out_last;
    assign o_out_ch.bad_padding = r_out_bad;

endmodule

// ===== hw/rtl/des_pkcs_checker.sv =====
// Port-level assertions for the DES cipher, bound to the top level.
module des_pkcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_block,
    input logic [3:0]  i_out_bytes,
    input logic        i_out_last,
    input logic        i_out_bad
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result word present right after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_block))
        else $error("Stalled result word changed.");

    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad |->
            i_out_last && i_out_bytes == 4'd0 && i_out_block == 64'd0)
        else $error("Bad padding word is malformed.");

    a_short_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bytes != 4'd8 |-> i_out_last)
        else $error("Short result word is not the last of its message.");

    a_no_accept_from_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !(i_in_valid && i_in_ready && i_out_valid))
        else $error("Result present while the first word is taken.");

endmodule

bind des_block_mode_pkcs7_cipher des_pkcs_checker u_des_pkcs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_ch.valid),
    .i_in_ready (i_in_ch.ready),
    .i_out_valid(o_out_ch.valid),
    .i_out_ready(o_out_ch.ready),
    .i_out_block(o_out_ch.out_block),
    .i_out_bytes(o_out_ch.out_valid_bytes),
    .i_out_last (o_out_ch.out_last),
    .i_out_bad  (o_out_ch.bad_padding)
);
